### rtl/core/assert_macros.svh
// assertion helpers shared by the checker files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked at every rising edge out of reset
`define ASSERT_IMPLIES(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked at every rising edge out of reset
`define ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/core/bpi_pkg.sv
package bpi_pkg;

    // board and binomial table geometry
    localparam int unsigned SQUARES   = 32;
    localparam int unsigned TBL_DIM   = SQUARES + 1;
    localparam int unsigned TBL_DEPTH = TBL_DIM * TBL_DIM;
    localparam int unsigned ADDR_W    = $clog2(TBL_DEPTH);
    localparam int unsigned SQ_W      = $clog2(SQUARES);
    localparam int unsigned CNT_W     = $clog2(SQUARES + 1);
    localparam int unsigned RANK_W    = SQ_W - 2;
    localparam int unsigned WORD_W    = 32;
    localparam int unsigned IN_W      = 4 * WORD_W;

    // datapath operations issued by the controller
    typedef enum logic [3:0] {
        OP_NOP,
        OP_FILL_RD,
        OP_FILL_WR,
        OP_LOAD,
        OP_MEN,
        OP_KING,
        OP_RNG_B,
        OP_RNG_W,
        OP_RNG_K,
        OP_MUL_R12,
        OP_MUL_R123,
        OP_MUL_WM,
        OP_MUL_BK,
        OP_MUL_WK,
        OP_MUL_FIN,
        OP_PUSH
    } op_t;

    typedef struct packed {
        op_t              op;
        logic [SQ_W-1:0]  sq;
    } cmd_t;

    typedef struct packed {
        logic fill_last;
        logic out_free;
    } sts_t;

    // flat address of entry C(n,k) in the binomial memory
    function automatic logic [ADDR_W-1:0] tbl_addr(input logic [CNT_W-1:0] n,
                                                   input logic [CNT_W-1:0] k);
        tbl_addr = ADDR_W'(n) * ADDR_W'(TBL_DIM) + ADDR_W'(k);
    endfunction

endpackage

### rtl/core/bpi_datapath.sv
module bpi_datapath import bpi_pkg::*; (
    input  logic               aclk,
    input  logic               aresetn,
    input  cmd_t               cmd,
    input  logic [IN_W-1:0]    s_tdata,
    input  logic               m_tready,
    output sts_t               sts,
    output logic               m_tvalid,
    output logic [WORD_W-1:0]  m_tdata
);

    // binomial coefficient memory, filled by the pass after reset
    logic [WORD_W-1:0] mem [TBL_DEPTH];

    logic [WORD_W-1:0] bm_mask_reg, bk_mask_reg, wm_mask_reg, wk_mask_reg;
    logic [CNT_W-1:0]  fill_n_reg, fill_k_reg;
    logic [CNT_W-1:0]  bm_cnt_reg, wm_cnt_reg, bk_cnt_reg, wk_cnt_reg;
    logic [CNT_W-1:0]  bk_blk_reg, wk_blk_reg;
    logic [RANK_W-1:0] bm_rank_reg, wm_rank_reg;
    logic [WORD_W-1:0] bm_idx_reg, wm_idx_reg, bk_idx_reg, wk_idx_reg;
    logic [WORD_W-1:0] bm_range_reg, wm_range_reg, bk_range_reg;
    logic [WORD_W-1:0] r12_reg, r123_reg, prod_reg, total_reg;
    logic [WORD_W-1:0] rd_a_reg, rd_b_reg, m_tdata_reg;
    logic              m_tvalid_reg;
    op_t               pend_op_reg;
    logic              pend_a_reg, pend_b_reg;

    logic [ADDR_W-1:0] addr_a, addr_b, fill_addr;
    logic              hit_a, hit_b;
    logic [SQ_W-1:0]   sq, wsq;
    logic [CNT_W-1:0]  fill_n_m1, fill_k_m1, bm_hi_n, bm_lo_n, wm_hi_n, wm_lo_n;
    logic [CNT_W:0]    bk_free_n;
    logic [WORD_W-1:0] fill_val, a_val, b_val, mul_a, mul_b, mul_p;

    assign sq  = cmd.sq;
    assign wsq = ~cmd.sq;

    assign fill_n_m1 = (fill_n_reg == '0) ? '0 : fill_n_reg - CNT_W'(1);
    assign fill_k_m1 = (fill_k_reg == '0) ? '0 : fill_k_reg - CNT_W'(1);
    assign fill_addr = tbl_addr(fill_n_reg, fill_k_reg);

    assign bm_hi_n = (CNT_W'(bm_rank_reg) + CNT_W'(1)) << 2;
    assign bm_lo_n = CNT_W'(bm_rank_reg) << 2;
    assign wm_hi_n = (CNT_W'(wm_rank_reg) + CNT_W'(1)) << 2;
    assign wm_lo_n = CNT_W'(wm_rank_reg) << 2;
    assign bk_free_n = (CNT_W+1)'(SQUARES) - {1'b0, bm_cnt_reg} - {1'b0, wm_cnt_reg};

    // read address generation for the two memory ports
    always_comb begin
        addr_a = '0;
        addr_b = '0;
        hit_a  = 1'b0;
        hit_b  = 1'b0;
        case (cmd.op)
            OP_FILL_RD: begin
                addr_a = tbl_addr(fill_n_m1, fill_k_m1);
                addr_b = tbl_addr(fill_n_m1, fill_k_reg);
            end
            OP_MEN: begin
                hit_a  = bm_mask_reg[sq];
                addr_a = tbl_addr(CNT_W'(sq), bm_cnt_reg + CNT_W'(1));
                hit_b  = wm_mask_reg[wsq];
                addr_b = tbl_addr(CNT_W'(sq), wm_cnt_reg + CNT_W'(1));
            end
            OP_KING: begin
                hit_a  = bk_mask_reg[sq];
                addr_a = tbl_addr(CNT_W'(sq) - bk_blk_reg, bk_cnt_reg + CNT_W'(1));
                hit_b  = wk_mask_reg[sq];
                addr_b = tbl_addr(CNT_W'(sq) - wk_blk_reg, wk_cnt_reg + CNT_W'(1));
            end
            OP_RNG_B: begin
                hit_a  = 1'b1;
                hit_b  = 1'b1;
                addr_a = tbl_addr(bm_hi_n, bm_cnt_reg);
                addr_b = tbl_addr(bm_lo_n, bm_cnt_reg);
            end
            OP_RNG_W: begin
                hit_a  = 1'b1;
                hit_b  = 1'b1;
                addr_a = tbl_addr(wm_hi_n, wm_cnt_reg);
                addr_b = tbl_addr(wm_lo_n, wm_cnt_reg);
            end
            OP_RNG_K: begin
                // a negative free-square count gives a zero radix
                hit_a  = ~bk_free_n[CNT_W];
                addr_a = hit_a ? tbl_addr(bk_free_n[CNT_W-1:0], bk_cnt_reg) : '0;
            end
            default: ;
        endcase
    end

    // binomial addition recurrence for the fill pass
    always_comb begin
        if (fill_k_reg == '0) begin
            fill_val = WORD_W'(1);
        end else if (fill_n_reg == '0 || fill_k_reg > fill_n_reg) begin
            fill_val = '0;
        end else begin
            fill_val = rd_a_reg + rd_b_reg;
        end
    end

    assign a_val = pend_a_reg ? rd_a_reg : '0;
    assign b_val = pend_b_reg ? rd_b_reg : '0;

    // shared 32x32 multiplier, low word only
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (cmd.op)
            OP_MUL_R12: begin
                mul_a = bm_range_reg;
                mul_b = wm_range_reg;
            end
            OP_MUL_R123: begin
                mul_a = r12_reg;
                mul_b = bk_range_reg;
            end
            OP_MUL_WM: begin
                mul_a = wm_idx_reg;
                mul_b = bm_range_reg;
            end
            OP_MUL_BK: begin
                mul_a = bk_idx_reg;
                mul_b = r12_reg;
            end
            OP_MUL_WK: begin
                mul_a = wk_idx_reg;
                mul_b = r123_reg;
            end
            default: ;
        endcase
    end

    assign mul_p = mul_a * mul_b;

    // memory write and registered reads
    always_ff @(posedge aclk) begin
        if (cmd.op == OP_FILL_WR) begin
            mem[fill_addr] <= fill_val;
        end
        rd_a_reg <= mem[addr_a];
        rd_b_reg <= mem[addr_b];
    end

    // control state: fill counters, read tracking, output valid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fill_n_reg   <= '0;
            fill_k_reg   <= '0;
            pend_op_reg  <= OP_NOP;
            pend_a_reg   <= 1'b0;
            pend_b_reg   <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            pend_op_reg <= cmd.op;
            pend_a_reg  <= hit_a;
            pend_b_reg  <= hit_b;
            if (cmd.op == OP_FILL_WR) begin
                if (fill_k_reg == CNT_W'(TBL_DIM - 1)) begin
                    fill_k_reg <= '0;
                    fill_n_reg <= fill_n_reg + CNT_W'(1);
                end else begin
                    fill_k_reg <= fill_k_reg + CNT_W'(1);
                end
            end
            if (cmd.op == OP_PUSH) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // payload: scan counters, sub-indexes, radices and products
    always_ff @(posedge aclk) begin
        case (cmd.op)
            OP_LOAD: begin
                bm_mask_reg <= s_tdata[WORD_W-1:0];
                bk_mask_reg <= s_tdata[2*WORD_W-1:WORD_W];
                wm_mask_reg <= s_tdata[3*WORD_W-1:2*WORD_W];
                wk_mask_reg <= s_tdata[4*WORD_W-1:3*WORD_W];
                bm_cnt_reg  <= '0;
                wm_cnt_reg  <= '0;
                bk_cnt_reg  <= '0;
                wk_cnt_reg  <= '0;
                bk_blk_reg  <= '0;
                wk_blk_reg  <= '0;
                bm_rank_reg <= '0;
                wm_rank_reg <= '0;
                bm_idx_reg  <= '0;
                wm_idx_reg  <= '0;
                bk_idx_reg  <= '0;
                wk_idx_reg  <= '0;
            end
            OP_MEN: begin
                if (bm_mask_reg[sq]) begin
                    bm_cnt_reg  <= bm_cnt_reg + CNT_W'(1);
                    bm_rank_reg <= sq[SQ_W-1:2];
                end
                if (wm_mask_reg[wsq]) begin
                    wm_cnt_reg  <= wm_cnt_reg + CNT_W'(1);
                    wm_rank_reg <= sq[SQ_W-1:2];
                end
            end
            OP_KING: begin
                if (bk_mask_reg[sq]) begin
                    bk_cnt_reg <= bk_cnt_reg + CNT_W'(1);
                end
                if (wk_mask_reg[sq]) begin
                    wk_cnt_reg <= wk_cnt_reg + CNT_W'(1);
                end
                if (bm_mask_reg[sq] || wm_mask_reg[sq]) begin
                    bk_blk_reg <= bk_blk_reg + CNT_W'(1);
                end
                if (bm_mask_reg[sq] || bk_mask_reg[sq] || wm_mask_reg[sq]) begin
                    wk_blk_reg <= wk_blk_reg + CNT_W'(1);
                end
            end
            OP_MUL_R12: begin
                r12_reg   <= mul_p;
                total_reg <= bm_idx_reg;
            end
            OP_MUL_R123: begin
                r123_reg <= mul_p;
            end
            OP_MUL_WM: begin
                prod_reg <= mul_p;
            end
            OP_MUL_BK, OP_MUL_WK: begin
                total_reg <= total_reg + prod_reg;
                prod_reg  <= mul_p;
            end
            OP_MUL_FIN: begin
                total_reg <= total_reg + prod_reg;
            end
            OP_PUSH: begin
                m_tdata_reg <= total_reg;
            end
            default: ;
        endcase

        // table data returning in the cycle after its read
        case (pend_op_reg)
            OP_MEN: begin
                bm_idx_reg <= bm_idx_reg + a_val;
                wm_idx_reg <= wm_idx_reg + b_val;
            end
            OP_KING: begin
                bk_idx_reg <= bk_idx_reg + a_val;
                wk_idx_reg <= wk_idx_reg + b_val;
            end
            OP_RNG_B: begin
                bm_range_reg <= (bm_cnt_reg == '0) ? WORD_W'(1) : rd_a_reg - rd_b_reg;
                if (bm_rank_reg != '0) begin
                    bm_idx_reg <= bm_idx_reg - rd_b_reg;
                end
            end
            OP_RNG_W: begin
                wm_range_reg <= (wm_cnt_reg == '0) ? WORD_W'(1) : rd_a_reg - rd_b_reg;
                if (wm_rank_reg != '0) begin
                    wm_idx_reg <= wm_idx_reg - rd_b_reg;
                end
            end
            OP_RNG_K: begin
                bk_range_reg <= (bk_cnt_reg == '0) ? WORD_W'(1) : a_val;
            end
            default: ;
        endcase
    end

    assign sts.fill_last = (fill_n_reg == CNT_W'(TBL_DIM - 1)) &&
                           (fill_k_reg == CNT_W'(TBL_DIM - 1));
    assign sts.out_free  = ~m_tvalid_reg | m_tready;
    assign m_tvalid      = m_tvalid_reg;
    assign m_tdata       = m_tdata_reg;

endmodule

### rtl/core/bpi_ctrl.sv
module bpi_ctrl import bpi_pkg::*; (
    input  logic aclk,
    input  logic aresetn,
    input  logic s_tvalid,
    input  sts_t sts,
    output logic s_tready,
    output cmd_t cmd
);

    typedef enum logic [14:0] {
        ST_FILL_RD  = 15'b000000000000001,
        ST_FILL_WR  = 15'b000000000000010,
        ST_IDLE     = 15'b000000000000100,
        ST_MEN      = 15'b000000000001000,
        ST_KING     = 15'b000000000010000,
        ST_RNG_B    = 15'b000000000100000,
        ST_RNG_W    = 15'b000000001000000,
        ST_RNG_K    = 15'b000000010000000,
        ST_MUL_R12  = 15'b000000100000000,
        ST_MUL_R123 = 15'b000001000000000,
        ST_MUL_WM   = 15'b000010000000000,
        ST_MUL_BK   = 15'b000100000000000,
        ST_MUL_WK   = 15'b001000000000000,
        ST_MUL_FIN  = 15'b010000000000000,
        ST_OUT      = 15'b100000000000000
    } state_t;

    state_t          state_reg, state_next;
    logic [SQ_W-1:0] sq_reg, sq_next;

    // sequencer: fill pass, square scan, radices, products, output
    always_comb begin
        state_next = state_reg;
        sq_next    = sq_reg;
        cmd.op     = OP_NOP;
        cmd.sq     = sq_reg;
        case (state_reg)
            ST_FILL_RD: begin
                cmd.op     = OP_FILL_RD;
                state_next = ST_FILL_WR;
            end
            ST_FILL_WR: begin
                cmd.op     = OP_FILL_WR;
                state_next = sts.fill_last ? ST_IDLE : ST_FILL_RD;
            end
            ST_IDLE: begin
                if (s_tvalid) begin
                    cmd.op     = OP_LOAD;
                    sq_next    = '0;
                    state_next = ST_MEN;
                end
            end
            ST_MEN: begin
                cmd.op     = OP_MEN;
                state_next = ST_KING;
            end
            ST_KING: begin
                cmd.op = OP_KING;
                if (sq_reg == SQ_W'(SQUARES - 1)) begin
                    state_next = ST_RNG_B;
                end else begin
                    sq_next    = sq_reg + SQ_W'(1);
                    state_next = ST_MEN;
                end
            end
            ST_RNG_B: begin
                cmd.op     = OP_RNG_B;
                state_next = ST_RNG_W;
            end
            ST_RNG_W: begin
                cmd.op     = OP_RNG_W;
                state_next = ST_RNG_K;
            end
            ST_RNG_K: begin
                cmd.op     = OP_RNG_K;
                state_next = ST_MUL_R12;
            end
            ST_MUL_R12: begin
                cmd.op     = OP_MUL_R12;
                state_next = ST_MUL_R123;
            end
            ST_MUL_R123: begin
                cmd.op     = OP_MUL_R123;
                state_next = ST_MUL_WM;
            end
            ST_MUL_WM: begin
                cmd.op     = OP_MUL_WM;
                state_next = ST_MUL_BK;
            end
            ST_MUL_BK: begin
                cmd.op     = OP_MUL_BK;
                state_next = ST_MUL_WK;
            end
            ST_MUL_WK: begin
                cmd.op     = OP_MUL_WK;
                state_next = ST_MUL_FIN;
            end
            ST_MUL_FIN: begin
                cmd.op     = OP_MUL_FIN;
                state_next = ST_OUT;
            end
            ST_OUT: begin
                if (sts.out_free) begin
                    cmd.op     = OP_PUSH;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // state registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_FILL_RD;
            sq_reg    <= '0;
        end else begin
            state_reg <= state_next;
            sq_reg    <= sq_next;
        end
    end

    assign s_tready = (state_reg == ST_IDLE);

endmodule

### rtl/core/board_position_to_index_core.sv
// Ranks a checkers endgame position, given as four 32-square occupancy masks, into one
// 32-bit database index (combinatorial number system, mixed-radix combination, wrapping
// modulo 2^32). After reset the block builds its 33x33 binomial coefficient memory with
// the addition rule C(n,k) = C(n-1,k-1) + C(n-1,k), with a read step and a write step per
// entry, and accepts no transaction until that fill pass is done. After that a position
// is taken only once the previous one is through: the 32 squares are scanned in a men
// step and a king step each, because every square needs four binomial lookups and the
// coefficient memory has two read ports; the RNG states then read the radices, and the
// MUL states drive the single shared 32x32 multiplier and the final sums.
// The result sits in an output register, so a new position is taken while the previous
// index still waits on the master side.
module board_position_to_index_core import bpi_pkg::*; (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_tvalid,
    output logic               s_tready,
    // black_men [31:0], black_kings [63:32], white_men [95:64], white_kings [127:96]
    input  logic [IN_W-1:0]    s_tdata,
    output logic               m_tvalid,
    input  logic               m_tready,
    // position_index [31:0]
    output logic [WORD_W-1:0]  m_tdata
);

    cmd_t cmd;
    sts_t sts;

    // sequencer
    bpi_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .sts      (sts),
        .s_tready (s_tready),
        .cmd      (cmd)
    );

    // table memory, accumulators and multiplier
    bpi_datapath u_datapath (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd      (cmd),
        .s_tdata  (s_tdata),
        .m_tready (m_tready),
        .sts      (sts),
        .m_tvalid (m_tvalid),
        .m_tdata  (m_tdata)
    );

endmodule

### rtl/core/bpi_checker.sv
`include "assert_macros.svh"

module bpi_checker (
    input logic          aclk,
    input logic          aresetn,
    input logic          s_tvalid,
    input logic          s_tready,
    input logic          m_tvalid,
    input logic          m_tready,
    input logic [31:0]   m_tdata
);

    // a stalled result transaction keeps its data
    `ASSERT_NEXT(a_out_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "result changed while stalled")

    // one position at a time: input closes right after a transaction
    `ASSERT_NEXT(a_busy_after_accept, aclk, aresetn, s_tvalid && s_tready, !s_tready, "input ready right after acceptance")

    // the input is still closed during the square scan
    `ASSERT_IMPLIES(a_busy_scan, aclk, aresetn, s_tvalid && s_tready, ##3 !s_tready, "input ready during square scan")

    // a new result appears only out of the busy phase
    `ASSERT_IMPLIES(a_result_from_busy, aclk, aresetn, $rose(m_tvalid), $past(!s_tready), "result raised while idle")

endmodule

bind board_position_to_index_core bpi_checker u_bpi_checker (.*);
